// File: design/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared constants, codes and types of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int DATAW    = 32;
    localparam int IDXW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW     = $clog2(CAPACITY + 1);
    // compare width: holds a non-negative index and any count, plus headroom
    localparam int CMPW     = ((CNTW > 7) ? CNTW : 7) + 1;
    localparam int GROUP    = 8;
    localparam int NGRP     = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [2:0] ACT_GET  = 3'd0;
    localparam logic [2:0] ACT_HEAD = 3'd1;
    localparam logic [2:0] ACT_TAIL = 3'd2;
    localparam logic [2:0] ACT_AT   = 3'd3;
    localparam logic [2:0] ACT_DEL  = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [DATAW-1:0] RV_MISS = {DATAW{1'b1}};
    localparam logic [DATAW-1:0] RV_NONE = '0;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDXW-1:0]  pos;
        logic [DATAW-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic             use_tree;
        logic [DATAW-1:0] rv;
        logic             found;
        logic [1:0]       status;
        logic [6:0]       occupancy;
    } pend_t;

endpackage

// File: design/ils_req_if.sv
// ----------------------------------------------------------------------------
// ils_req_if
// Request channel: one list action per item.
// ----------------------------------------------------------------------------
interface ils_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  action;
    logic signed [7:0]  index;
    logic signed [31:0] value;

    modport source (output valid, output action, output index, output value, input ready);
    modport sink   (input valid, input action, input index, input value, output ready);
endinterface

// File: design/ils_rsp_if.sv
// ----------------------------------------------------------------------------
// ils_rsp_if
// Response channel: one result item per action.
// ----------------------------------------------------------------------------
interface ils_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic               found;
    logic        [1:0]  status;
    logic        [6:0]  occupancy;

    modport source (output valid, output read_value, output found, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input read_value, input found, input status,
                    input occupancy, output ready);
endinterface

// File: design/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// One list position: holds an element, shifts toward either neighbor.
// ----------------------------------------------------------------------------
module ils_cell (
    input  logic                      clk,
    input  logic [ils_pkg::IDXW-1:0]  cell_idx,
    input  ils_pkg::cell_ctrl_t       ctrl,
    input  logic [ils_pkg::DATAW-1:0] left_elem,
    input  logic [ils_pkg::DATAW-1:0] right_elem,
    output logic [ils_pkg::DATAW-1:0] elem,
    output logic [ils_pkg::DATAW-1:0] rd_data
);

    logic [ils_pkg::DATAW-1:0] elem_reg;
    logic [ils_pkg::DATAW-1:0] elem_next;
    logic                      at_pos;
    logic                      past_pos;

    assign at_pos   = (cell_idx == ctrl.pos);
    assign past_pos = (cell_idx > ctrl.pos);

    always_comb
    begin
        elem_next = elem_reg;
        unique case (ctrl.op)
            ils_pkg::CELL_INSERT:
            begin
                if (at_pos)
                    elem_next = ctrl.value;
                else if (past_pos)
                    elem_next = left_elem;
            end
            ils_pkg::CELL_DELETE:
            begin
                if (at_pos || past_pos)
                    elem_next = right_elem;
            end
            default:
                elem_next = elem_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    assign elem    = elem_reg;
    // drive this element onto the read tree only when addressed
    assign rd_data = elem_reg & {ils_pkg::DATAW{at_pos}};

endmodule

// File: design/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// Action decode: range checks, cell command, result fields and new count.
// ----------------------------------------------------------------------------
module ils_ctrl (
    input  logic [2:0]               action,
    input  logic signed [7:0]        index,
    input  logic [31:0]              value,
    input  logic [ils_pkg::CNTW-1:0] count,
    output ils_pkg::cell_ctrl_t      cell_ctrl,
    output ils_pkg::pend_t           result,
    output logic [ils_pkg::CNTW-1:0] count_next
);

    logic [ils_pkg::CMPW-1:0] idx_ext;
    logic [ils_pkg::CMPW-1:0] cnt_ext;
    logic                     neg;
    logic                     in_range;
    logic                     beyond;
    logic                     full;
    logic [ils_pkg::IDXW-1:0] idx_pos;
    logic [ils_pkg::IDXW-1:0] tail_pos;

    assign neg      = index[7];
    assign idx_ext  = ils_pkg::CMPW'(index[6:0]);
    assign cnt_ext  = ils_pkg::CMPW'(count);
    assign in_range = !neg && (idx_ext < cnt_ext);
    assign beyond   = !neg && (idx_ext > cnt_ext);
    assign full     = (count == ils_pkg::CNTW'(ils_pkg::CAPACITY));
    assign idx_pos  = ils_pkg::IDXW'(idx_ext);
    assign tail_pos = ils_pkg::IDXW'(count);

    always_comb
    begin
        cell_ctrl.op    = ils_pkg::CELL_HOLD;
        cell_ctrl.pos   = idx_pos;
        cell_ctrl.value = value;
        result.use_tree = 1'b0;
        result.rv       = ils_pkg::RV_NONE;
        result.found    = 1'b0;
        result.status   = ils_pkg::ST_DONE;
        count_next      = count;

        unique case (action)
            ils_pkg::ACT_GET:
            begin
                if (in_range)
                begin
                    result.use_tree = 1'b1;
                    result.found    = 1'b1;
                end
                else
                begin
                    result.rv     = ils_pkg::RV_MISS;
                    result.status = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::ACT_HEAD, ils_pkg::ACT_TAIL, ils_pkg::ACT_AT:
            begin
                if (action == ils_pkg::ACT_HEAD)
                    cell_ctrl.pos = '0;
                else if (action == ils_pkg::ACT_TAIL)
                    cell_ctrl.pos = tail_pos;
                else if (neg)
                    cell_ctrl.pos = '0;

                if ((action == ils_pkg::ACT_AT) && beyond)
                    result.status = ils_pkg::ST_RANGE;
                else if (full)
                    result.status = ils_pkg::ST_FULL;
                else
                begin
                    cell_ctrl.op = ils_pkg::CELL_INSERT;
                    count_next   = count + 1'b1;
                end
            end
            ils_pkg::ACT_DEL:
            begin
                if (in_range)
                begin
                    cell_ctrl.op = ils_pkg::CELL_DELETE;
                    count_next   = count - 1'b1;
                end
                else
                    result.status = ils_pkg::ST_RANGE;
            end
            default:
            begin
                result.rv     = ils_pkg::RV_MISS;
                result.status = ils_pkg::ST_RANGE;
            end
        endcase

        result.occupancy = 7'(count_next);
    end

endmodule

// File: design/ils_read_tree.sv
// ----------------------------------------------------------------------------
// ils_read_tree
// Two-level OR tree over the cells' read outputs, registered between levels.
// ----------------------------------------------------------------------------
module ils_read_tree (
    input  logic                      clk,
    input  logic                      load,
    input  logic [ils_pkg::DATAW-1:0] leaf [ils_pkg::CAPACITY],
    output logic [ils_pkg::DATAW-1:0] data
);

    logic [ils_pkg::DATAW-1:0] group_reg  [ils_pkg::NGRP];
    logic [ils_pkg::DATAW-1:0] group_next [ils_pkg::NGRP];

    always_comb
    begin
        for (int g = 0; g < ils_pkg::NGRP; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < ils_pkg::GROUP; k++)
            begin
                if (g * ils_pkg::GROUP + k < ils_pkg::CAPACITY)
                    group_next[g] = group_next[g] | leaf[g * ils_pkg::GROUP + k];
            end
        end
    end

    // capture the partial ORs together with the action that reads them
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < ils_pkg::NGRP; g++)
                group_reg[g] <= group_next[g];
        end
    end

    always_comb
    begin
        data = '0;
        for (int g = 0; g < ils_pkg::NGRP; g++)
            data = data | group_reg[g];
    end

endmodule

// File: design/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of up to CAPACITY signed 32-bit values kept in a row of cells.
// ----------------------------------------------------------------------------
// Accepts one action per clock while req.ready is high: get, add at head,
// add at tail, add at index, delete at index. Each action gives exactly one
// result item, in order. An insert or delete shifts the cells at and past its
// position toward a neighbor at the edge of acceptance, so no action waits on
// an earlier one. A get reads the addressed cell through a two-level OR
// tree with a register after the first level; every result then passes
// through the pending stage and the output register. With the response side
// ready, the block sustains one item per cycle; a stalled response backs up
// into one pending stage before the request side stalls. Storage has no reset
// and no clearing pass: only positions below the element count are ever read.
// ----------------------------------------------------------------------------
module indexed_list_store (
    input  logic      clk,
    input  logic      rst_n,
    ils_req_if.sink   req,
    ils_rsp_if.source rsp
);

    // element count, the only control state of the list itself
    logic [ils_pkg::CNTW-1:0]  count_reg;
    logic [ils_pkg::CNTW-1:0]  count_next;

    // pending stage: decoded result waiting for the read tree's second level
    logic                      pend_valid_reg;
    logic                      pend_valid_next;
    ils_pkg::pend_t            pend_reg;

    // output register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [31:0]               out_rv_reg;
    logic                      out_found_reg;
    logic [1:0]                out_status_reg;
    logic [6:0]                out_occ_reg;

    logic                      accept;
    logic                      pend_move;
    ils_pkg::cell_ctrl_t       dec_ctrl;
    ils_pkg::cell_ctrl_t       cell_ctrl;
    ils_pkg::pend_t            dec_result;
    logic [ils_pkg::DATAW-1:0] elem    [ils_pkg::CAPACITY];
    logic [ils_pkg::DATAW-1:0] rd_data [ils_pkg::CAPACITY];
    logic [ils_pkg::DATAW-1:0] tree_data;

    // Handshake: take a new item whenever the pending stage is empty or can
    // advance into the output register this cycle.
    assign pend_move = pend_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !pend_valid_reg || !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    ils_ctrl u_ctrl (
        .action     (req.action),
        .index      (req.index),
        .value      (req.value),
        .count      (count_reg),
        .cell_ctrl  (dec_ctrl),
        .result     (dec_result),
        .count_next (count_next)
    );

    // Hold every cell unless an item is accepted this cycle.
    always_comb
    begin
        cell_ctrl = dec_ctrl;
        if (!accept)
            cell_ctrl.op = ils_pkg::CELL_HOLD;
    end

    // Row of cells: each takes its left neighbor on insert, its right
    // neighbor on delete. The ends fold back onto the new value or itself.
    for (genvar i = 0; i < ils_pkg::CAPACITY; i++)
    begin : g_cell
        logic [ils_pkg::DATAW-1:0] left_in;
        logic [ils_pkg::DATAW-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = cell_ctrl.value;
        end
        else
        begin : g_mid_l
            assign left_in = elem[i-1];
        end

        if (i == ils_pkg::CAPACITY - 1)
        begin : g_last
            assign right_in = elem[i];
        end
        else
        begin : g_mid_r
            assign right_in = elem[i+1];
        end

        ils_cell u_cell (
            .clk        (clk),
            .cell_idx   (ils_pkg::IDXW'(i)),
            .ctrl       (cell_ctrl),
            .left_elem  (left_in),
            .right_elem (right_in),
            .elem       (elem[i]),
            .rd_data    (rd_data[i])
        );
    end

    // Capture the first tree level from the cells before they shift.
    ils_read_tree u_tree (
        .clk  (clk),
        .load (accept),
        .leaf (rd_data),
        .data (tree_data)
    );

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
            pend_valid_next = 1'b1;
        else if (pend_move)
            pend_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pend_move)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= dec_result;
        if (pend_move)
        begin
            out_rv_reg     <= pend_reg.use_tree ? tree_data : pend_reg.rv;
            out_found_reg  <= pend_reg.found;
            out_status_reg <= pend_reg.status;
            out_occ_reg    <= pend_reg.occupancy;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_rv_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.occupancy  = out_occ_reg;

`ifndef SYNTHESIS
    // count never runs past the row of cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ils_pkg::CNTW'(ils_pkg::CAPACITY))
        else $error("element count above capacity");

    // an insert that reaches the cells grows the list by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctrl.op == ils_pkg::CELL_INSERT |=>
        count_reg == ils_pkg::CNTW'($past(count_reg) + 1'b1))
        else $error("insert did not advance the count");

    // a delete that reaches the cells shrinks the list by one
    a_delete_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctrl.op == ils_pkg::CELL_DELETE |=>
        count_reg == ils_pkg::CNTW'($past(count_reg) - 1'b1))
        else $error("delete did not drop the count");

    // a pending result with a free output register moves on at once
    a_pend_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pending result stuck");
`endif

endmodule

// File: test/tb_indexed_list_store.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_store
// Self-checking testbench of the indexed list store.
// ----------------------------------------------------------------------------
// Drives list actions on the request channel and checks every response item
// against a behavioral copy of the list. The copy is kept in the testbench
// and is updated at the edge where each action is accepted. A short directed
// part covers the empty list, every insert position, reads and deletes at and
// beyond both ends, and the unused action codes. Random traffic then swings
// the list between empty and full under several idling phases on both sides.
// ----------------------------------------------------------------------------
module tb_indexed_list_store;

    localparam int IDLE_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int END_CYCLES = 8;      // slack after draining, to catch stray responses

    typedef struct {
        logic signed [ils_pkg::DATAW-1:0] read_value;
        logic                             found;
        logic [1:0]                       status;
        logic [6:0]                       occupancy;
    } list_result_t;

    logic clk;
    logic rst_n;

    ils_req_if req_bus ();
    ils_rsp_if rsp_bus ();

    indexed_list_store i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Behavioral copy of the list: position 0 is the head.
    logic signed [ils_pkg::DATAW-1:0] list_vals [ils_pkg::CAPACITY];
    int                               list_count;

    // Results predicted for accepted actions, oldest first.
    list_result_t                     pending_results [$];

    int send_idle_pct;
    int rsp_stall_pct;
    int err_count;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Insert val before position pos (pos never exceeds the count here).
    function automatic logic [1:0] insert_value(input int pos,
                                                input logic signed [ils_pkg::DATAW-1:0] val);
        if (list_count >= ils_pkg::CAPACITY)
            return ils_pkg::ST_FULL;
        for (int i = list_count; i > pos; i--)
            list_vals[i] = list_vals[i-1];
        list_vals[pos] = val;
        list_count++;
        return ils_pkg::ST_DONE;
    endfunction

    // Apply one accepted action to the list copy and return the response it gives.
    function automatic list_result_t apply_action(input logic [2:0] act,
                                                  input logic signed [7:0] idx,
                                                  input logic signed [ils_pkg::DATAW-1:0] val);
        list_result_t res;
        int           pos;
        res.read_value = ils_pkg::RV_NONE;
        res.found      = 1'b0;
        res.status     = ils_pkg::ST_DONE;
        pos            = int'(idx);
        case (act)
            ils_pkg::ACT_GET:
            begin
                if (pos < 0 || pos >= list_count)
                begin
                    res.read_value = ils_pkg::RV_MISS;
                    res.status     = ils_pkg::ST_RANGE;
                end
                else
                begin
                    res.read_value = list_vals[pos];
                    res.found      = 1'b1;
                end
            end
            ils_pkg::ACT_HEAD: res.status = insert_value(0, val);
            ils_pkg::ACT_TAIL: res.status = insert_value(list_count, val);
            ils_pkg::ACT_AT:
            begin
                // a position past the tail is rejected before the full check
                if (pos > list_count)
                    res.status = ils_pkg::ST_RANGE;
                else
                    res.status = insert_value((pos < 0) ? 0 : pos, val);
            end
            ils_pkg::ACT_DEL:
            begin
                if (pos < 0 || pos >= list_count)
                    res.status = ils_pkg::ST_RANGE;
                else
                begin
                    for (int i = pos; i + 1 < list_count; i++)
                        list_vals[i] = list_vals[i+1];
                    list_count--;
                end
            end
            default:
            begin
                // unused codes do nothing and report out of range
                res.read_value = ils_pkg::RV_MISS;
                res.status     = ils_pkg::ST_RANGE;
            end
        endcase
        res.occupancy = list_count[6:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Send one action: idle at random first, then hold valid until accepted.
    // Valid stays high after acceptance; an idle in the next call or wait_drained lowers it.
    task automatic send_action(input logic [2:0] act,
                               input logic signed [7:0] idx,
                               input logic signed [ils_pkg::DATAW-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.action <= act;
        req_bus.index  <= idx;
        req_bus.value  <= val;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        pending_results.push_back(apply_action(act, idx, val));
    endtask

    // Hold off the request side until every predicted result has come back.
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
    endtask

    // ------------------------------------------------------------------------
    // Response side: stall at random, check each accepted item in order
    // ------------------------------------------------------------------------

    task automatic check_field(input string what, input logic signed [32:0] want,
                               input logic signed [32:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t want;
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected response item: read_value %0d status %0d",
                             $time, rsp_bus.read_value, rsp_bus.status);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_value", 33'(want.read_value),
                                33'(rsp_bus.read_value));
                    check_field("found", 33'(want.found), 33'(rsp_bus.found));
                    check_field("status", 33'(want.status), 33'(rsp_bus.status));
                    check_field("occupancy", 33'(want.occupancy),
                                33'(rsp_bus.occupancy));
                end
            end
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                 (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty list: every read, delete and indexed insert past the tail misses;
    // unused action codes come back as no-ops.
    task automatic test_empty_store();
        send_action(ils_pkg::ACT_GET, 8'sd0, 32'sd0);
        send_action(ils_pkg::ACT_GET, -8'sd1, 32'sd0);
        send_action(ils_pkg::ACT_DEL, 8'sd0, 32'sd0);
        send_action(ils_pkg::ACT_AT, 8'sd1, 32'sd5);
        send_action(3'd5, 8'sd127, 32'sh7FFF_FFFF);
        send_action(3'd6, -8'sd128, -32'sd1);
        send_action(3'd7, 8'sd0, 32'sd0);
    endtask

    // Every insert position: negative index lands at the head, index equal to
    // the count appends, index past the count is rejected.
    task automatic test_insert_positions();
        send_action(ils_pkg::ACT_AT, -8'sd128, 32'sh7FFF_FFFF);
        send_action(ils_pkg::ACT_TAIL, 8'sd0, 32'sh8000_0000);
        send_action(ils_pkg::ACT_HEAD, 8'sd127, 32'sd0);
        send_action(ils_pkg::ACT_AT, 8'(list_count), -32'sd1);
        send_action(ils_pkg::ACT_AT, 8'sd2, 32'sh5A5A_5A5A);
        send_action(ils_pkg::ACT_AT, 8'sd127, 32'sd1);
        send_action(ils_pkg::ACT_AT, 8'(list_count + 1), 32'sd2);
    endtask

    // Reads and deletes at both ends and just outside them.
    task automatic test_read_and_delete();
        send_action(ils_pkg::ACT_GET, 8'sd0, 32'sd0);
        send_action(ils_pkg::ACT_GET, 8'(list_count - 1), 32'sd0);
        send_action(ils_pkg::ACT_GET, 8'(list_count), 32'sd0);
        send_action(ils_pkg::ACT_GET, 8'sd127, 32'sd0);
        send_action(ils_pkg::ACT_GET, -8'sd128, 32'sd0);
        send_action(ils_pkg::ACT_DEL, -8'sd1, 32'sd0);
        send_action(ils_pkg::ACT_DEL, 8'(list_count), 32'sd0);
        send_action(ils_pkg::ACT_DEL, 8'sd0, 32'sd0);
        send_action(ils_pkg::ACT_DEL, 8'(list_count - 1), 32'sd0);
        send_action(ils_pkg::ACT_DEL, 8'sd127, 32'sd0);
    endtask

    // Random actions biased to grow the list into the full case or to shrink
    // it toward empty. Most indexes fall just around the valid range.
    task automatic test_random_traffic(input int n_items, input bit grow);
        int              roll;
        int              pick;
        int              ins_pct;
        int              del_pct;
        logic [2:0]      act;
        logic signed [7:0] idx;
        ins_pct = grow ? 70 : 5;
        del_pct = grow ? 10 : 75;
        for (int n = 0; n < n_items; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
            begin
                pick = $urandom_range(0, 2);
                act  = (pick == 0) ? ils_pkg::ACT_HEAD :
                       (pick == 1) ? ils_pkg::ACT_TAIL : ils_pkg::ACT_AT;
            end
            else if (roll < ins_pct + del_pct)
                act = ils_pkg::ACT_DEL;
            else if (roll < 95)
                act = ils_pkg::ACT_GET;
            else
                act = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 3) != 0)
                idx = 8'($urandom_range(0, list_count + 2) - 1);
            else
                idx = 8'($urandom_range(0, 255));
            send_action(act, idx, $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        req_bus.valid  <= 1'b0;
        req_bus.action <= ils_pkg::ACT_GET;
        req_bus.index  <= '0;
        req_bus.value  <= '0;
        rst_n          <= 1'b0;
        list_count     = 0;
        set_idling(0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_insert_positions();
        test_read_and_delete();

        // Each phase starts from a drained pipe, so the sender pauses until
        // every expected result is back before the idling changes.
        wait_drained();
        test_random_traffic(120, 1'b1);
        test_random_traffic(120, 1'b0);

        wait_drained();
        set_idling(72, 0);
        test_random_traffic(120, 1'b1);
        test_random_traffic(120, 1'b0);

        wait_drained();
        set_idling(0, 72);
        test_random_traffic(120, 1'b1);
        test_random_traffic(120, 1'b0);

        wait_drained();
        set_idling(11, 11);
        test_random_traffic(120, 1'b1);
        test_random_traffic(120, 1'b0);

        // Drain, then keep clocking to catch stray responses.
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
